FILE: src/hkrd_pkg.sv
// shared types and constants for the keyboard report differ
// used by every module under src, no dependencies
`default_nettype none

package hkrd_pkg;

  localparam int SLOT_COUNT     = 6;
  localparam int MIN_REPORT_LEN = 8;
  localparam int EVENT_COUNT    = 2 * SLOT_COUNT;
  localparam int KEY_W          = 8;
  localparam int LEN_W          = 7;
  localparam int MOD_W          = 8;

  // queue depth must stay a power of two, pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t             key_slot_0;
    key_t             key_slot_1;
    key_t             key_slot_2;
    key_t             key_slot_3;
    key_t             key_slot_4;
    key_t             key_slot_5;
    logic [LEN_W-1:0] report_length;
    logic [MOD_W-1:0] modifiers;
  } key_report_t;

  typedef struct packed {
    logic             event_valid;
    key_t             key_code;
    logic             pressed;
    logic [MOD_W-1:0] event_modifiers;
    logic             report_ok;
    logic             last;
  } key_event_t;

  // one classified report: low half of the mask is presses, high half releases
  typedef struct packed {
    logic [EVENT_COUNT-1:0]  ev_mask;
    key_t [SLOT_COUNT-1:0]   fresh;
    key_t [SLOT_COUNT-1:0]   held;
    logic [MOD_W-1:0]        mods;
    logic                    ok;
  } diff_entry_t;

endpackage

`default_nettype wire

FILE: src/hid_keyboard_report_differ.sv
// top level of the keyboard report differ
// depends on hkrd_pkg, hkrd_front, hkrd_queue, hkrd_back
//
// report channel: one boot keyboard report per word (six key slots, length,
// modifiers); taken at a clock edge with report_valid high and report_stall low.
// result channel: key event words; result_valid/result_stall, same rule.
// a report shorter than 8 bytes gives one marker word with report_ok low and
// leaves the held keys alone. an accepted report gives one press word per new
// key, then one release word per dropped key, or one marker word if nothing
// changed; the final word of each report has last set.
// the first word of a report passes through the queue, the back end's current entry
// and the output register. the back end gives one word per cycle while result_stall
// is low; a report with n events gives max(n, 1) words, at most 12. the front end takes
// a report every cycle while the two-entry queue has room, so reports keep
// coming in while the output register waits on result_stall.
// a stalled result word holds; everything stops cleanly behind it.
// reset (rst, synchronous) clears the held keys, the queue and the output.
`default_nettype none

module hid_keyboard_report_differ
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        report_valid,
  output logic        report_stall,
  input  key_report_t report,
  output logic        result_valid,
  input  logic        result_stall,
  output key_event_t  result
);

  logic        push;
  logic        full;
  logic        pop;
  logic        q_valid;
  diff_entry_t wr_entry;
  diff_entry_t rd_entry;

  hkrd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .full         (full),
    .push         (push),
    .entry        (wr_entry)
  );

  hkrd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .rd_entry (rd_entry)
  );

  hkrd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (rd_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: src/hkrd_front.sv
// front end: accepts reports, keeps the held keys and classifies changes
// depends on hkrd_pkg
`default_nettype none

module hkrd_front
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        report_valid,
  output logic        report_stall,
  input  key_report_t report,
  input  logic        full,
  output logic        push,
  output diff_entry_t entry
);

  key_t [SLOT_COUNT-1:0]  held;
  key_t [SLOT_COUNT-1:0]  fresh;
  logic [EVENT_COUNT-1:0] mask;
  logic                   ok;
  logic                   found;

  assign report_stall = full;
  assign push         = report_valid && !full;
  assign ok           = report.report_length >= LEN_W'(MIN_REPORT_LEN);

  always_comb begin
    fresh[0] = report.key_slot_0;
    fresh[1] = report.key_slot_1;
    fresh[2] = report.key_slot_2;
    fresh[3] = report.key_slot_3;
    fresh[4] = report.key_slot_4;
    fresh[5] = report.key_slot_5;
  end

  always_comb begin
    mask  = '0;
    found = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      // press: new key not among held keys
      found = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        found = found | (held[j] == fresh[i]);
      end
      mask[i] = (fresh[i] != '0) && !found;
      // release: held key not among new keys
      found = 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        found = found | (fresh[j] == held[i]);
      end
      mask[SLOT_COUNT+i] = (held[i] != '0) && !found;
    end
  end

  always_comb begin
    entry.ev_mask = ok ? mask : '0;
    entry.fresh   = fresh;
    entry.held    = held;
    entry.mods    = report.modifiers;
    entry.ok      = ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (push && ok) begin
      held <= fresh;
    end
  end

  a_short_keeps_held: assert property (@(posedge clk) disable iff (rst)
    (push && !ok) |=> $stable(held))
    else $error("held keys changed on a short report");

endmodule

`default_nettype wire

FILE: src/hkrd_queue.sv
// small queue of classified reports between front and back end
// depends on hkrd_pkg
`default_nettype none

module hkrd_queue
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  diff_entry_t wr_entry,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output diff_entry_t rd_entry
);

  diff_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign q_valid  = count != '0;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: src/hkrd_back.sv
// back end: walks the event mask of one report, one word per cycle while result_stall is low
// depends on hkrd_pkg
`default_nettype none

module hkrd_back
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  diff_entry_t q_entry,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output key_event_t  result
);

  logic                   cur_valid;
  diff_entry_t            cur;
  logic [EVENT_COUNT-1:0] rem;
  logic [EVENT_COUNT-1:0] pick;
  logic [EVENT_COUNT-1:0] rest;
  logic                   cur_last;
  logic                   adv;
  logic                   load;
  key_event_t             res;

  // lowest pending event first: presses in slot order, then releases
  assign pick     = rem & (~rem + 1'b1);
  assign rest     = rem & ~pick;
  assign cur_last = rest == '0;
  assign adv      = cur_valid && (!result_valid || !result_stall);
  assign load     = q_valid && (!cur_valid || (adv && cur_last));
  assign pop      = load;

  always_comb begin
    res = '0;
    if (rem == '0) begin
      // marker word
      res.report_ok = cur.ok;
      res.last      = 1'b1;
    end else begin
      res.event_valid     = 1'b1;
      res.event_modifiers = cur.mods;
      res.report_ok       = 1'b1;
      res.last            = cur_last;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (pick[i]) begin
          res.key_code = cur.fresh[i];
          res.pressed  = 1'b1;
        end
        if (pick[SLOT_COUNT+i]) begin
          res.key_code = cur.held[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res;
    end
    if (load) begin
      cur <= q_entry;
      rem <= q_entry.ev_mask;
    end else if (adv) begin
      rem <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
      end else if (adv && cur_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.event_valid) |-> result.last)
    else $error("marker word without last");

  a_event_has_key: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.event_valid) |-> (result.key_code != '0 && result.report_ok))
    else $error("event word with empty key or rejected report");

  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    pop |=> cur_valid)
    else $error("loaded entry not held");

endmodule

`default_nettype wire

FILE: tb/sv/tb_hid_keyboard_report_differ.sv
// self-checking testbench for hid_keyboard_report_differ
// depends on hkrd_pkg and the differ rtl; reports go in on a valid/stall channel and
// event words are checked against an in-bench model of the held-key compare
`timescale 1ns / 100ps

module tb_hid_keyboard_report_differ;
  import hkrd_pkg::*;

  localparam int RANDOM_REPORTS = 110;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef key_t [SLOT_COUNT-1:0] slots_t;

  typedef struct {
    key_report_t rpt;
    bit          typed;
    key_event_t  want;
  } report_row_t;

  localparam key_event_t MARK_OK = '{event_valid: 1'b0, key_code: '0, pressed: 1'b0,
                                     event_modifiers: '0, report_ok: 1'b1, last: 1'b1};
  localparam key_event_t MARK_SHORT = '{event_valid: 1'b0, key_code: '0, pressed: 1'b0,
                                        event_modifiers: '0, report_ok: 1'b0, last: 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        report_valid = 1'b0;
  logic        report_stall;
  key_report_t report = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  key_event_t  result;

  report_row_t report_script[$];
  key_event_t  pending_events[$];
  slots_t      model_held;
  bit          no_idle;
  int          error_count;
  int          idle_cycles;
  int          stall_left;
  int          short_reports;
  int          press_words;
  int          release_words;
  int          marker_words;

  hid_keyboard_report_differ i_dut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit key_present(slots_t set, key_t code);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (set[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic key_report_t make_report(key_t k0, key_t k1, key_t k2, key_t k3,
                                              key_t k4, key_t k5, int len, int mods);
    key_report_t r;
    r.key_slot_0    = k0;
    r.key_slot_1    = k1;
    r.key_slot_2    = k2;
    r.key_slot_3    = k3;
    r.key_slot_4    = k4;
    r.key_slot_5    = k5;
    r.report_length = len[LEN_W-1:0];
    r.modifiers     = mods[MOD_W-1:0];
    return r;
  endfunction

  // presses in new-slot order, then releases in held-slot order; held keys replaced unless short
  task automatic diff_against_held(input key_report_t r, input bit keep);
    slots_t     fresh;
    key_event_t ev;
    key_event_t evs[$];
    fresh = '{r.key_slot_5, r.key_slot_4, r.key_slot_3,
              r.key_slot_2, r.key_slot_1, r.key_slot_0};
    if (r.report_length < MIN_REPORT_LEN) begin
      evs.push_back(MARK_SHORT);
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (fresh[i] != '0 && !key_present(model_held, fresh[i])) begin
          ev = '{event_valid: 1'b1, key_code: fresh[i], pressed: 1'b1,
                 event_modifiers: r.modifiers, report_ok: 1'b1, last: 1'b0};
          evs.push_back(ev);
        end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (model_held[i] != '0 && !key_present(fresh, model_held[i])) begin
          ev = '{event_valid: 1'b1, key_code: model_held[i], pressed: 1'b0,
                 event_modifiers: r.modifiers, report_ok: 1'b1, last: 1'b0};
          evs.push_back(ev);
        end
      end
      model_held = fresh;
      if (evs.size() == 0) evs.push_back(MARK_OK);
      else evs[evs.size()-1].last = 1'b1;
    end
    if (keep) begin
      foreach (evs[i]) pending_events.push_back(evs[i]);
    end
  endtask

  task automatic add_row(input key_report_t r, input bit typed, input key_event_t want);
    report_row_t row;
    row.rpt   = r;
    row.typed = typed;
    row.want  = want;
    report_script.push_back(row);
  endtask

  task automatic build_directed();
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   8, 8'hff), 1, MARK_OK);
    add_row(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,   0, 8'hff), 1, MARK_SHORT);
    add_row(make_report(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,   8, 8'h00), 0, '0);
    // same set in another order, so nothing changes
    add_row(make_report(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04,  64, 8'h55), 1, MARK_OK);
    add_row(make_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,   7, 8'haa), 1, MARK_SHORT);
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 127, 8'haa), 0, '0);
    add_row(make_report(8'hff, 8'hff, 8'h01, 8'h00, 8'h80, 8'hff,   9, 8'h01), 0, '0);
    add_row(make_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   8, 8'h02), 0, '0);
    add_row(make_report(8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,   8, 8'h04), 0, '0);
    // disjoint set: six presses and six releases
    add_row(make_report(8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f,   8, 8'h08), 0, '0);
    add_row(make_report(8'h0f, 8'h0e, 8'h0d, 8'h0c, 8'h0b, 8'h0a,   8, 8'h33), 1, MARK_OK);
    add_row(make_report(8'h10, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00,   8, 8'h80), 0, '0);
    add_row(make_report(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   8, 8'h40), 0, '0);
    add_row(make_report(8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h21,   8, 8'h0f), 0, '0);
    add_row(make_report(8'h7f, 8'h80, 8'hfe, 8'h01, 8'h02, 8'h40,  63, 8'hf0), 0, '0);
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   6, 8'hff), 1, MARK_SHORT);
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   8, 8'h00), 0, '0);
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,   8, 8'h00), 1, MARK_OK);
    add_row(make_report(8'hff, 8'hfe, 8'hfd, 8'hfc, 8'hfb, 8'hfa,  65, 8'hff), 0, '0);
    add_row(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff,   8, 8'h00), 0, '0);
  endtask

  // mostly typing-like edits of the previous report, some full random sets and repeats
  task automatic build_random(input int count);
    slots_t keys;
    int     kind;
    int     len;
    keys = '0;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(1, 2)) begin
          keys[$urandom_range(0, SLOT_COUNT-1)] =
            ($urandom_range(0, 2) == 0) ? key_t'(0) : key_t'($urandom_range(4, 40));
        end
      end else if (kind < 88) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          keys[i] = ($urandom_range(0, 3) == 0) ? key_t'(0) : key_t'($urandom());
        end
      end
      kind = $urandom_range(0, 99);
      if (kind < 12) len = $urandom_range(0, MIN_REPORT_LEN-1);
      else if (kind < 80) len = MIN_REPORT_LEN;
      else len = $urandom_range(MIN_REPORT_LEN+1, 127);
      add_row(make_report(keys[0], keys[1], keys[2], keys[3], keys[4], keys[5],
                          len, $urandom()), 0, '0);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side: check each accepted word, then choose the next stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected word, expected none got %h", $time, result);
          error_count++;
        end else begin
          check_field("event_valid", pending_events[0].event_valid, result.event_valid);
          check_field("key_code", pending_events[0].key_code, result.key_code);
          check_field("pressed", pending_events[0].pressed, result.pressed);
          check_field("event_modifiers", pending_events[0].event_modifiers,
                      result.event_modifiers);
          check_field("report_ok", pending_events[0].report_ok, result.report_ok);
          check_field("last", pending_events[0].last, result.last);
          if (!pending_events[0].event_valid) marker_words++;
          else if (pending_events[0].pressed) press_words++;
          else release_words++;
          void'(pending_events.pop_front());
        end
      end
      if (stall_left == 0) stall_left = pick_gap();
      result_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (report_valid && !report_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
      $display("tb_hid_keyboard_report_differ: FAIL");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    report_row_t row;
    int          gap;
    model_held = '0;
    build_directed();
    build_random(RANDOM_REPORTS);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < report_script.size(); n++) begin
      row = report_script[n];
      // one stretch of back-to-back traffic on both sides
      no_idle = (n >= 60 && n < 85);
      gap = pick_gap();
      if (gap > 0) begin
        report_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      report_valid <= 1'b1;
      report <= row.rpt;
      @(posedge clk);
      while (report_stall) @(posedge clk);
      if (row.rpt.report_length < MIN_REPORT_LEN) short_reports++;
      diff_against_held(row.rpt, !row.typed);
      if (row.typed) pending_events.push_back(row.want);
    end
    report_valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d reports (%0d short) under random gaps and stalls",
             report_script.size(), short_reports);
    $display("checked %0d press, %0d release and %0d marker words, %0d errors",
             press_words, release_words, marker_words, error_count);
    if (error_count == 0) begin
      $display("tb_hid_keyboard_report_differ: PASS");
    end else begin
      $display("tb_hid_keyboard_report_differ: FAIL");
    end
    $finish;
  end

endmodule

FILE: hid_keyboard_report_differ.f
src/hkrd_pkg.sv
src/hkrd_front.sv
src/hkrd_queue.sv
src/hkrd_back.sv
src/hid_keyboard_report_differ.sv
tb/sv/tb_hid_keyboard_report_differ.sv
